>>> sv/sfwp_pkg.sv
package sfwp_pkg;

	// Result codes carried on the kind port.
	typedef enum logic [1:0] {
		KIND_VALID    = 2'd0,
		KIND_UNSTABLE = 2'd1,
		KIND_LENGTH   = 2'd2,
		KIND_NUMBER   = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_FRAME_SPAN  = 1'b0,
		REG_MOTION_MASK = 1'b1
	} reg_idx_t;

	localparam logic [7:0] STX_BYTE   = 8'h02;
	localparam logic [7:0] CR_BYTE    = 8'h0D;
	localparam logic [7:0] CHAR_BLANK = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int         COUNT_W    = 7;
	localparam logic [6:0] COUNT_MAX  = 7'd127;
	localparam logic [6:0] SPAN_RESET = 7'd16;
	localparam logic [7:0] MASK_RESET = 8'h08;

	localparam int          WEIGHT_W   = 17;
	localparam logic [16:0] WEIGHT_MAX = 17'h1FFFF;

	// Mantissa and rounding word: eight digits plus the rounding half fit in 28 bits.
	localparam int X_W    = 28;
	localparam int FRAC_W = 4;

	// floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x.
	localparam logic [31:0] RECIP_TEN   = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT = 35;

	// Control part of a closed frame handed from the front to the back.
	typedef struct packed {
		kind_t kind;   // length or motion verdict, or KIND_VALID
		logic  parse;  // the weight text decides the result
	} job_ctl_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_BLANK) || (c >= CHAR_TAB && c <= CR_BYTE);
	endfunction

	// Half of one unit of the last kept digit: 5 * 10^f.
	function automatic logic [X_W-1:0] half_unit(input logic [FRAC_W-1:0] f);
		logic [X_W-1:0] h;
		case (f)
			4'd0:    h = 28'd5;
			4'd1:    h = 28'd50;
			4'd2:    h = 28'd500;
			4'd3:    h = 28'd5000;
			4'd4:    h = 28'd50000;
			4'd5:    h = 28'd500000;
			4'd6:    h = 28'd5000000;
			4'd7:    h = 28'd50000000;
			default: h = 28'd0;
		endcase
		return h;
	endfunction

endpackage

>>> sv/sfwp_front.sv
module sfwp_front
	import sfwp_pkg::*;
#(
	parameter int DIGIT_COUNT   = 6,
	parameter int DIGIT_OFFSET  = 4,
	parameter int STATUS_OFFSET = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [7:0]               cfg_data,
	input  logic                     in_take,
	input  logic [7:0]               rx_byte,
	output logic                     push,
	output job_ctl_t                 job_ctl,
	output logic [DIGIT_COUNT*8-1:0] job_text
);

	logic [COUNT_W-1:0] span_q;
	logic [7:0]         mask_q;
	logic               in_frame_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic [7:0]         status_q;
	logic [7:0]         digit_q [DIGIT_COUNT];
	logic               open_frame;
	logic               store_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_RESET;
			mask_q <= MASK_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_SPAN:  span_q <= cfg_data[COUNT_W-1:0];
				REG_MOTION_MASK: mask_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	assign count_next = (count_q < COUNT_MAX) ? count_q + 7'd1 : count_q;
	assign open_frame = in_take && !in_frame_q && (rx_byte == STX_BYTE);
	assign push       = in_take && in_frame_q && (rx_byte == CR_BYTE);
	assign store_byte = in_take && in_frame_q && (rx_byte != CR_BYTE) && (count_next < COUNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
		end else if (open_frame) begin
			in_frame_q <= 1'b1;
			count_q    <= '0;
		end else if (in_take && in_frame_q) begin
			count_q <= count_next;
			if (rx_byte == CR_BYTE) begin
				in_frame_q <= 1'b0;
			end
		end
	end

	// Every frame starts from a zero status byte and a blank weight field.
	always_ff @(posedge clk) begin
		if (open_frame) begin
			status_q <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digit_q[i] <= CHAR_BLANK;
			end
		end else if (store_byte) begin
			if (count_next == COUNT_W'(STATUS_OFFSET)) begin
				status_q <= rx_byte;
			end
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				if (count_next == COUNT_W'(DIGIT_OFFSET + i)) begin
					digit_q[i] <= rx_byte;
				end
			end
		end
	end

	always_comb begin
		job_ctl.parse = 1'b0;
		if (count_next >= COUNT_MAX || count_next != span_q) begin
			job_ctl.kind = KIND_LENGTH;
		end else if ((status_q & mask_q) != 8'd0) begin
			job_ctl.kind = KIND_UNSTABLE;
		end else begin
			job_ctl.kind  = KIND_VALID;
			job_ctl.parse = 1'b1;
		end
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			job_text[i*8 +: 8] = digit_q[i];
		end
	end

	a_push_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> in_frame_q)
		else $error("frame closed while no frame was open");

endmodule

>>> sv/sfwp_queue.sv
module sfwp_queue #(
	parameter int WIDTH = 51
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

>>> sv/sfwp_back.sv
module sfwp_back
	import sfwp_pkg::*;
#(
	parameter int DIGIT_COUNT = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  job_ctl_t                 q_ctl,
	input  logic [DIGIT_COUNT*8-1:0] q_text,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               kind,
	output logic [WEIGHT_W-1:0]      weight
);

	logic adv;

	// Stage 1: trim, sign, digit and point checks.
	logic             valid_s1;
	kind_t            kind_s1;
	logic             zero_s1;
	logic [3:0]       dval_s1 [DIGIT_COUNT];
	logic [DIGIT_COUNT-1:0] use_s1;
	logic [FRAC_W-1:0] frac_s1;

	kind_t             p_kind;
	logic              p_zero;
	logic [DIGIT_COUNT-1:0] p_use;
	logic [FRAC_W-1:0] p_frac;

	// Stage 2: mantissa. Stage 3: mantissa plus rounding half.
	logic              valid_s2, valid_s3;
	kind_t             kind_s2, kind_s3;
	logic              zero_s2, zero_s3;
	logic [FRAC_W-1:0] frac_s2, frac_s3;
	logic [X_W-1:0]    mant_s2, x_s3;
	logic [X_W-1:0]    mant_c;

	// Divide-by-ten stages, stage k at pipeline position 4 + k.
	logic              div_valid_s4 [DIGIT_COUNT];
	kind_t             div_kind_s4  [DIGIT_COUNT];
	logic              div_zero_s4  [DIGIT_COUNT];
	logic [FRAC_W-1:0] div_frac_s4  [DIGIT_COUNT];
	logic [X_W-1:0]    div_x_s4     [DIGIT_COUNT];
	logic [X_W-1:0]    div_src      [DIGIT_COUNT];
	logic [X_W-1:0]    div_res      [DIGIT_COUNT];

	logic              out_valid_q;
	kind_t             kind_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [X_W-1:0]    last_x;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;

	always_comb begin
		logic [7:0]        c;
		logic              any_nb, neg, dot, bad;
		logic [FRAC_W-1:0] lo, hi, ndig;
		any_nb = 1'b0;
		neg    = 1'b0;
		dot    = 1'b0;
		bad    = 1'b0;
		lo     = '0;
		hi     = '0;
		ndig   = '0;
		p_frac = '0;
		p_use  = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (!is_blank(q_text[i*8 +: 8])) begin
				if (!any_nb) begin
					lo = FRAC_W'(i);
				end
				any_nb = 1'b1;
				hi     = FRAC_W'(i + 1);
			end
		end
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			c = q_text[i*8 +: 8];
			if (FRAC_W'(i) >= lo && FRAC_W'(i) < hi) begin
				if (FRAC_W'(i) == lo && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
					neg = (c == CHAR_MINUS);
				end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
					p_use[i] = 1'b1;
					ndig     = ndig + 4'd1;
					if (dot) begin
						p_frac = p_frac + 4'd1;
					end
				end else if (c == CHAR_DOT && !dot) begin
					dot = 1'b1;
				end else begin
					bad = 1'b1;
				end
			end
		end
		if (!q_ctl.parse) begin
			p_kind = q_ctl.kind;
			p_zero = 1'b1;
		end else if (!any_nb) begin
			p_kind = KIND_VALID;
			p_zero = 1'b1;
		end else if (bad || ndig == '0) begin
			p_kind = KIND_NUMBER;
			p_zero = 1'b1;
		end else begin
			// Negative values fall below the smallest reported weight.
			p_kind = KIND_VALID;
			p_zero = neg;
		end
	end

	always_comb begin
		mant_c = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (use_s1[i]) begin
				mant_c = (mant_c << 3) + (mant_c << 1) + X_W'(dval_s1[i]);
			end
		end
	end

	always_comb begin
		logic [63:0] prod;
		div_src[0] = x_s3;
		for (int k = 1; k < DIGIT_COUNT; k++) begin
			div_src[k] = div_x_s4[k-1];
		end
		for (int k = 0; k < DIGIT_COUNT; k++) begin
			prod       = 64'(div_src[k]) * 64'(RECIP_TEN);
			div_res[k] = X_W'(prod >> RECIP_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < DIGIT_COUNT; k++) begin
				div_valid_s4[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s1        <= q_valid;
			valid_s2        <= valid_s1;
			valid_s3        <= valid_s2;
			div_valid_s4[0] <= valid_s3;
			for (int k = 1; k < DIGIT_COUNT; k++) begin
				div_valid_s4[k] <= div_valid_s4[k-1];
			end
			out_valid_q <= div_valid_s4[DIGIT_COUNT-1];
		end
	end

	assign last_x = div_x_s4[DIGIT_COUNT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= p_kind;
			zero_s1 <= p_zero;
			use_s1  <= p_use;
			frac_s1 <= p_frac;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				dval_s1[i] <= q_text[i*8 +: 4];
			end

			kind_s2 <= kind_s1;
			zero_s2 <= zero_s1;
			frac_s2 <= frac_s1;
			mant_s2 <= mant_c;

			kind_s3 <= kind_s2;
			zero_s3 <= zero_s2;
			frac_s3 <= frac_s2;
			x_s3    <= mant_s2 + half_unit(frac_s2);

			div_kind_s4[0] <= kind_s3;
			div_zero_s4[0] <= zero_s3;
			div_frac_s4[0] <= frac_s3;
			for (int k = 1; k < DIGIT_COUNT; k++) begin
				div_kind_s4[k] <= div_kind_s4[k-1];
				div_zero_s4[k] <= div_zero_s4[k-1];
				div_frac_s4[k] <= div_frac_s4[k-1];
			end
			// Stage k divides only while k stays within the fraction digits plus one.
			div_x_s4[0] <= div_res[0];
			for (int k = 1; k < DIGIT_COUNT; k++) begin
				div_x_s4[k] <= (FRAC_W'(k) <= div_frac_s4[k-1]) ? div_res[k] : div_src[k];
			end

			kind_q <= div_kind_s4[DIGIT_COUNT-1];
			if (div_zero_s4[DIGIT_COUNT-1]) begin
				weight_q <= '0;
			end else if (last_x > X_W'(WEIGHT_MAX)) begin
				weight_q <= WEIGHT_MAX;
			end else begin
				weight_q <= last_x[WEIGHT_W-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign weight    = weight_q;

	a_weight_only_when_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_VALID |-> weight_q == '0)
		else $error("nonzero weight on an error result");

endmodule

>>> sv/scale_frame_weight_parser.sv
// A result passes the frame queue, the parse, mantissa and rounding stages, the divide
// chain and the output register after the CR byte that closes its frame is accepted.
// Throughput: one byte per cycle unless stalled; one divide stage per weight character.
// The input stalls only when the two-entry frame queue is full while the output is stalled.
// Reset (arst_n low, asynchronous) drops any open frame, empties the queue and pipeline, and
// loads frame_span with 16 and motion_mask with 0x08.
module scale_frame_weight_parser
	import sfwp_pkg::*;
#(
	parameter int DIGIT_COUNT   = 6,
	parameter int DIGIT_OFFSET  = 4,
	parameter int STATUS_OFFSET = 2
) (
	input  logic                clk,
	input  logic                arst_n,

	// Configuration writes: index 0 is frame_span, index 1 is motion_mask.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [7:0]          cfg_data,

	// Received byte stream.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,

	// One result per closed frame.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [WEIGHT_W-1:0] weight
);

	localparam int TEXT_W = DIGIT_COUNT * 8;
	localparam int JOB_W  = $bits(job_ctl_t) + TEXT_W;

	logic              in_take;
	logic              push;
	job_ctl_t          job_ctl;
	logic [TEXT_W-1:0] job_text;
	logic [JOB_W-1:0]  q_dout;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	job_ctl_t          q_ctl;
	logic [TEXT_W-1:0] q_text;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// The front takes a byte in every cycle unless the frame queue has no room. A transaction
	// that carries a non-CR byte never needs room, but the stall is kept simple and uniform.
	assign in_stall = q_full;
	assign in_take  = in_valid && !in_stall;

	// The front tracks frame position, captures the status byte and weight characters, and
	// on CR makes the length and motion checks against the current configuration.
	sfwp_front #(
		.DIGIT_COUNT   (DIGIT_COUNT),
		.DIGIT_OFFSET  (DIGIT_OFFSET),
		.STATUS_OFFSET (STATUS_OFFSET)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_take   (in_take),
		.rx_byte   (rx_byte),
		.push      (push),
		.job_ctl   (job_ctl),
		.job_text  (job_text)
	);

	// A short queue of closed frames lets the byte stream keep flowing while the output
	// side is stalled.
	sfwp_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({job_ctl, job_text}),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_ctl  = job_ctl_t'(q_dout[JOB_W-1:TEXT_W]);
	assign q_text = q_dout[TEXT_W-1:0];

	// The back parses the weight text, builds the mantissa, adds the rounding half and
	// divides by ten once per fraction digit plus one, then saturates into the weight port.
	sfwp_back #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_ctl     (q_ctl),
		.q_text    (q_text),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.weight    (weight)
	);

endmodule
